FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ptab_pkg.sv
// Types, constants and tables for the point-to-angle-bin core.
package ptab_pkg;

	localparam int MAX_BINS_DEF = 1024;
	localparam int QW           = 17;      // quotient / angle-difference magnitude width
	localparam int CORDIC_STEPS = 17;
	localparam int HALF_PI_Q16  = 102944;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef enum logic [1:0] {
		CFG_ANGLE_START = 2'd0,
		CFG_ANGLE_STEP  = 2'd1,
		CFG_BEAM_COUNT  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic               func;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic        [15:0] point_intensity;
		logic        [9:0]  read_bin;
	} req_t;

	typedef struct packed {
		logic [9:0]  bin_number;
		logic        hit;
		logic [15:0] range_out;
		logic [15:0] intensity_out;
	} rsp_t;

	typedef struct packed {
		logic          hit;
		logic [15:0]   range;
		logic [QW-1:0] qm;
	} geom_res_t;

	typedef struct packed {
		logic        filled;
		logic [15:0] range;
		logic [15:0] intensity;
	} bin_entry_t;

	// atan(2^-i) in units of 2^-16 rad
	function automatic logic [15:0] atan_q16(input logic [4:0] i);
		logic [15:0] v;
		begin
			unique case (i)
				5'd0:  v = 16'd51472;
				5'd1:  v = 16'd30386;
				5'd2:  v = 16'd16055;
				5'd3:  v = 16'd8150;
				5'd4:  v = 16'd4091;
				5'd5:  v = 16'd2047;
				5'd6:  v = 16'd1024;
				5'd7:  v = 16'd512;
				5'd8:  v = 16'd256;
				5'd9:  v = 16'd128;
				5'd10: v = 16'd64;
				5'd11: v = 16'd32;
				5'd12: v = 16'd16;
				5'd13: v = 16'd8;
				5'd14: v = 16'd4;
				5'd15: v = 16'd2;
				5'd16: v = 16'd1;
				default: v = 16'd0;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: rtl/core/ptab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptab_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] wa,
	input  logic [W-1:0]         wd,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] ra,
	output logic [W-1:0]         rd
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

FILE: rtl/core/ptab_geom.sv
// Iterative range / angle / bin unit: one squarer, sqrt+CORDIC steps, restoring divide.
module ptab_geom #(
	parameter int MAX_BINS = ptab_pkg::MAX_BINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  px,
	input  logic signed [15:0]  py,
	input  logic signed [15:0]  angle_start,
	input  logic        [13:0]  angle_step,
	input  logic        [10:0]  beam_count,
	output logic                done,
	output ptab_pkg::geom_res_t res
);

	localparam int QW = ptab_pkg::QW;
	localparam logic [QW-1:0] MAXB_Q = QW'(MAX_BINS);
	localparam logic signed [19:0] HALF_PI = 20'(ptab_pkg::HALF_PI_Q16);
	localparam logic [4:0] LAST_STEP = 5'(ptab_pkg::CORDIC_STEPS - 1);

	typedef enum logic [5:0] {
		G_IDLE = 6'b000001,
		G_SQ   = 6'b000010,
		G_SUM  = 6'b000100,
		G_ITER = 6'b001000,
		G_ANG  = 6'b010000,
		G_DIV  = 6'b100000
	} gstate_t;

	gstate_t state_q;
	logic [4:0] cnt_q;
	logic done_q;

	logic signed [15:0] px_q, py_q;
	logic signed [15:0] mul_a;
	logic signed [31:0] prod;
	logic [31:0] sqx_q, s_q;
	logic [18:0] rem_q;
	logic [15:0] root_q, rng_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [19:0] z_q;
	logic zero_q, dneg_q;
	logic [QW-1:0] dq_q;
	logic [13:0] drem_q;

	// shared squarer
	assign mul_a = (state_q == G_SQ) ? px_q : py_q;
	assign prod  = mul_a * mul_a;

	logic signed [35:0] xe, ye, dx, dy;
	logic signed [19:0] atn, zr;
	logic [18:0] rem_n, trial;
	logic signed [16:0] ang;
	logic signed [17:0] d;
	logic [13:0] step_eff;
	logic [14:0] rs;
	logic rs_ge;

	always_comb begin
		xe    = $signed({{4{px_q[15]}}, px_q, 16'h0000});
		ye    = $signed({{4{py_q[15]}}, py_q, 16'h0000});
		dx    = cy_q >>> cnt_q;
		dy    = cx_q >>> cnt_q;
		atn   = $signed({4'h0, ptab_pkg::atan_q16(cnt_q)});
		rem_n = {rem_q[16:0], s_q[31:30]};
		trial = {1'b0, root_q, 2'b01};
		zr    = z_q + 20'sd4;
		ang   = zero_q ? 17'sd0 : 17'(zr >>> 3);
		d     = 18'(ang) - 18'(angle_start);
		step_eff = (angle_step == 14'd0) ? 14'd1 : angle_step;
		rs    = {drem_q, dq_q[QW-1]};
		rs_ge = (rs >= {1'b0, step_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: if (start) state_q <= G_SQ;
				G_SQ:   state_q <= G_SUM;
				G_SUM: begin
					cnt_q   <= '0;
					state_q <= G_ITER;
				end
				G_ITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_STEP) state_q <= G_ANG;
				end
				G_ANG: begin
					cnt_q   <= '0;
					state_q <= G_DIV;
				end
				G_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QW - 1)) begin
						state_q <= G_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				px_q <= px;
				py_q <= py;
			end
			G_SQ: sqx_q <= prod;
			G_SUM: begin
				s_q    <= sqx_q + 32'(prod);
				rem_q  <= '0;
				root_q <= '0;
				zero_q <= (px_q == 16'sd0) && (py_q == 16'sd0);
				if (px_q[15]) begin
					if (!py_q[15]) begin
						cx_q <= ye;
						cy_q <= -xe;
						z_q  <= HALF_PI;
					end else begin
						cx_q <= -ye;
						cy_q <= xe;
						z_q  <= -HALF_PI;
					end
				end else begin
					cx_q <= xe;
					cy_q <= ye;
					z_q  <= '0;
				end
			end
			G_ITER: begin
				if (!cy_q[35]) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + atn;
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - atn;
				end
				// 16 sqrt digits ride on the first 16 CORDIC steps
				if (!cnt_q[4]) begin
					s_q <= {s_q[29:0], 2'b00};
					if (rem_n >= trial) begin
						rem_q  <= rem_n - trial;
						root_q <= {root_q[14:0], 1'b1};
					end else begin
						rem_q  <= rem_n;
						root_q <= {root_q[14:0], 1'b0};
					end
				end
			end
			G_ANG: begin
				rng_q  <= (rem_q > {3'b000, root_q}) ? root_q + 16'd1 : root_q;
				dneg_q <= d[17];
				dq_q   <= QW'(d[17] ? -d : d);
				drem_q <= '0;
			end
			G_DIV: begin
				drem_q <= rs_ge ? 14'(rs - {1'b0, step_eff}) : rs[13:0];
				dq_q   <= {dq_q[QW-2:0], rs_ge};
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign res.qm    = dq_q;
	assign res.range = rng_q;
	assign res.hit   = !(dneg_q && (dq_q != '0)) && (dq_q < {6'd0, beam_count})
		&& (dq_q < MAXB_Q);

endmodule

FILE: rtl/core/point_to_angle_bin_min_range_core.sv
// Top level: point-to-laser-scan binning with minimum-range bins.
//
// Request channel (req_valid / req_stall / req): one item per handshake.
//   func = insert: the point's range (rounded hypot) and angle (CORDIC atan2)
//   are formed, bin = (angle - angle_start) / angle_step truncated toward zero;
//   a bin in use keeps the smaller range and takes the newest intensity.
//   func = read: returns the bin's stored range, intensity and filled mark,
//   then clears the bin.
// Result channel (rsp_valid / rsp_stall / rsp): exactly one result per request.
// Insert steps: squarer, 17 joint sqrt/CORDIC steps, angle, 17 restoring-divide
//   steps, handoff, RAM read-modify-write; a dropped point skips the RAM;
//   a read is only the RAM read-modify-write.
//   One request in flight: the next request can be taken while the result is presented.
// Reset: all control clears and a sweep over all MAX_BINS bins clears every
//   filled mark; req_stall stays high during the sweep. Config writes
//   (cfg_we / cfg_index / cfg_wdata) belong between requests.
// A stalled result is held in the output register; the next request is
//   taken meanwhile and waits at its end until the register frees.
module point_to_angle_bin_min_range_core #(
	parameter int MAX_BINS = ptab_pkg::MAX_BINS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ptab_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ptab_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_wdata
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int EW = $bits(ptab_pkg::bin_entry_t);

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_GEOM    = 6'b000100,
		S_RD_ADDR = 6'b001000,
		S_RD_DATA = 6'b010000,
		S_FIN     = 6'b100000
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;

	// configuration registers
	logic signed [15:0] start_q;
	logic [13:0] step_q;
	logic [10:0] beams_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= -16'sd25736;
			step_q  <= 14'd82;
			beams_q <= 11'd628;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptab_pkg::CFG_ANGLE_START: start_q <= cfg_wdata;
				ptab_pkg::CFG_ANGLE_STEP:  step_q  <= cfg_wdata[13:0];
				ptab_pkg::CFG_BEAM_COUNT:  beams_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	logic accept;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	// geometry unit
	logic geom_start, geom_done;
	ptab_pkg::geom_res_t geom_res;
	assign geom_start = accept && (req.func == ptab_pkg::FUNC_INSERT);

	ptab_geom #(.MAX_BINS(MAX_BINS)) u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (geom_start),
		.px          (req.point_x),
		.py          (req.point_y),
		.angle_start (start_q),
		.angle_step  (step_q),
		.beam_count  (beams_q),
		.done        (geom_done),
		.res         (geom_res)
	);

	// bin store: {filled, range, intensity}
	logic ram_we, ram_re;
	logic [AW-1:0] ram_wa, ram_ra;
	ptab_pkg::bin_entry_t ram_wd, ram_rd;

	ptab_ram #(.W(EW), .D(MAX_BINS)) u_bins (
		.clk (clk),
		.we  (ram_we),
		.wa  (ram_wa),
		.wd  (ram_wd),
		.re  (ram_re),
		.ra  (ram_ra),
		.rd  (ram_rd)
	);

	ptab_pkg::req_t req_q;
	logic [AW-1:0] addr_q;
	logic [15:0] rng_q;
	ptab_pkg::rsp_t res_q, rsp_q;
	logic rsp_valid_q;
	logic is_read;

	assign is_read = (req_q.func == ptab_pkg::FUNC_READ);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = addr_q;
		ram_wd = '0;
		ram_re = 1'b0;
		ram_ra = addr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
			end
			S_RD_ADDR: ram_re = 1'b1;
			S_RD_DATA: begin
				if (is_read) begin
					ram_we = ram_rd.filled;     // clear on read
				end else begin
					ram_we           = 1'b1;
					ram_wd.filled    = 1'b1;
					ram_wd.intensity = req_q.point_intensity;
					ram_wd.range     = (!ram_rd.filled || (rng_q < ram_rd.range))
						? rng_q : ram_rd.range;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output register loads from S_FIN, empties when the receiver takes it
			if ((state_q == S_FIN) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_BINS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (req.func == ptab_pkg::FUNC_INSERT) begin
							state_q <= S_GEOM;
						end else if (32'(req.read_bin) < MAX_BINS) begin
							state_q <= S_RD_ADDR;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_GEOM: begin
					if (geom_done) state_q <= geom_res.hit ? S_RD_ADDR : S_FIN;
				end
				S_RD_ADDR: state_q <= S_RD_DATA;
				S_RD_DATA: state_q <= S_FIN;
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			addr_q <= AW'(req.read_bin);
			// read miss keeps the asked bin
			res_q  <= '{bin_number: req.read_bin, hit: 1'b0, range_out: 16'd0,
				intensity_out: 16'd0};
		end
		if ((state_q == S_GEOM) && geom_done) begin
			rng_q             <= geom_res.range;
			addr_q            <= AW'(geom_res.qm);
			res_q.range_out   <= geom_res.range;
			res_q.hit         <= geom_res.hit;
			res_q.bin_number  <= geom_res.hit ? geom_res.qm[9:0] : 10'd0;
		end
		if ((state_q == S_RD_DATA) && is_read && ram_rd.filled) begin
			res_q.hit           <= 1'b1;
			res_q.range_out     <= ram_rd.range;
			res_q.intensity_out <= ram_rd.intensity;
		end
		if ((state_q == S_FIN) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/ptab_checker.sv
// Port-level checker for the point-to-angle-bin core, bound to the top level.
`include "assert_macros.svh"

module ptab_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input ptab_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ptab_pkg::rsp_t rsp,
	input logic           cfg_we,
	input logic [1:0]     cfg_index,
	input logic [15:0]    cfg_wdata
);

	`AST_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed under stall")
	`AST_NEXT(a_one_inflight, req_valid && !req_stall, req_stall, "second request taken while busy")
	`AST_SAME(a_miss_no_inten, rsp_valid && !rsp.hit, rsp.intensity_out == 16'd0, "miss carries intensity")
	`AST_SAME(a_range_max, rsp_valid, rsp.range_out <= 16'd46341, "range beyond hypot limit")

endmodule

bind point_to_angle_bin_min_range_core ptab_checker u_ptab_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the point-to-angle-bin core with minimum-range bins.
`timescale 1ns / 1ps

module testbench;

	localparam int NBINS = ptab_pkg::MAX_BINS_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ptab_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ptab_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	// Predictor copy of configuration and bin store
	logic signed [15:0] cur_start;
	logic [13:0] cur_step;
	logic [10:0] cur_beams;
	logic [15:0] scan_range [NBINS];
	logic [15:0] scan_inten [NBINS];
	logic scan_filled [NBINS];

	ptab_pkg::rsp_t pending_bins [$];
	int error_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	point_to_angle_bin_min_range_core uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver backpressure, changed at the falling edge
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Result checker
	always @(posedge clk) begin
		ptab_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_bins.size() == 0) begin
				report("unexpected result", rsp.bin_number, -1);
			end else begin
				want = pending_bins.pop_front();
				if (rsp.bin_number !== want.bin_number)
					report("bin_number", rsp.bin_number, want.bin_number);
				if (rsp.hit !== want.hit)
					report("hit", rsp.hit, want.hit);
				if (rsp.range_out !== want.range_out)
					report("range_out", rsp.range_out, want.range_out);
				if (rsp.intensity_out !== want.intensity_out)
					report("intensity_out", rsp.intensity_out, want.intensity_out);
			end
		end
	end

	// Rounded integer square root
	function automatic int unsigned round_root(input longint unsigned s);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int k = 16; k >= 0; k--) begin
			t = r | (64'd1 << k);
			if (t * t <= s)
				r = t;
		end
		if (s - r * r > r)
			r++;
		return int'(r);
	endfunction

	// Vectoring CORDIC angle, radians * 8192
	function automatic int point_angle(input int px, input int py);
		longint x, y, z, ox, dx, dy;
		longint atan_tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		if (px == 0 && py == 0)
			return 0;
		x = longint'(px) * 65536;
		y = longint'(py) * 65536;
		z = 0;
		if (px < 0) begin
			ox = x;
			if (py >= 0) begin
				x = y; y = -ox; z = 102944;
			end else begin
				x = -y; y = ox; z = -102944;
			end
		end
		for (int i = 0; i < 17; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_tab[i];
			end else begin
				x -= dx; y += dy; z -= atan_tab[i];
			end
		end
		return int'((z + 4) >>> 3);
	endfunction

	// Expected result of one request; updates the bin store copy
	function automatic ptab_pkg::rsp_t bin_outcome(input ptab_pkg::req_t r);
		ptab_pkg::rsp_t o;
		int rng, ang, d, stp, q;
		o = '0;
		if (r.func == ptab_pkg::FUNC_READ) begin
			o.bin_number = r.read_bin;
			if (scan_filled[r.read_bin]) begin
				o.hit = 1'b1;
				o.range_out = scan_range[r.read_bin];
				o.intensity_out = scan_inten[r.read_bin];
				scan_filled[r.read_bin] = 1'b0;
			end
		end else begin
			rng = round_root(longint'(r.point_x) * r.point_x
				+ longint'(r.point_y) * r.point_y);
			ang = point_angle(r.point_x, r.point_y);
			d = ang - int'(cur_start);
			stp = (cur_step == 0) ? 1 : int'(cur_step);
			q = d / stp;
			o.range_out = rng[15:0];
			if (q >= 0 && q < int'(cur_beams) && q < NBINS) begin
				if (!scan_filled[q] || rng < scan_range[q])
					scan_range[q] = rng[15:0];
				scan_filled[q] = 1'b1;
				scan_inten[q] = r.point_intensity;
				o.bin_number = q[9:0];
				o.hit = 1'b1;
			end
		end
		return o;
	endfunction

	// Send one request; valid stays high into the next request when no gap
	task automatic send_request(input ptab_pkg::req_t r);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
		pending_bins = {pending_bins, bin_outcome(r)};
	endtask

	// Lower valid, wait for all results and the block to settle
	task automatic drain;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_bins.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ptab_pkg::CFG_ANGLE_START: cur_start = val;
			ptab_pkg::CFG_ANGLE_STEP:  cur_step = val[13:0];
			ptab_pkg::CFG_BEAM_COUNT:  cur_beams = val[10:0];
			default: ;
		endcase
	endtask

	task automatic set_scan(input int start, input int stp, input int beams);
		drain();
		write_reg(ptab_pkg::CFG_ANGLE_START, 16'(start));
		write_reg(ptab_pkg::CFG_ANGLE_STEP, 16'(stp));
		write_reg(ptab_pkg::CFG_BEAM_COUNT, 16'(beams));
	endtask

	function automatic ptab_pkg::req_t make_point(input int x, input int y, input int inten);
		ptab_pkg::req_t r;
		r = '0;
		r.func = ptab_pkg::FUNC_INSERT;
		r.point_x = 16'(x);
		r.point_y = 16'(y);
		r.point_intensity = 16'(inten);
		r.read_bin = 10'($urandom);
		return r;
	endfunction

	function automatic ptab_pkg::req_t make_read(input int b);
		ptab_pkg::req_t r;
		r = ptab_pkg::req_t'($bits(ptab_pkg::req_t)'({$urandom, $urandom}));
		r.func = ptab_pkg::FUNC_READ;
		r.read_bin = 10'(b);
		return r;
	endfunction

	// Bin of a point under the current setting, without touching the store
	function automatic int bin_outcome_peek(input int x, input int y);
		int stp;
		stp = (cur_step == 0) ? 1 : int'(cur_step);
		return ((point_angle(x, y) - int'(cur_start)) / stp) & 10'h3FF;
	endfunction

	// Extreme coordinates, zero point, left half-plane, empty reads
	task automatic test_directed;
		send_request(make_read(0));
		send_request(make_read(1023));
		send_request(make_point(0, 0, 16'hFFFF));
		send_request(make_point(-32768, -32768, 1));
		send_request(make_point(32767, 32767, 0));
		send_request(make_point(-32768, 0, 16'h5555));
		send_request(make_point(-32768, -1, 16'hAAAA));
		send_request(make_point(32767, 0, 7));
		send_request(make_point(0, 32767, 8));
		send_request(make_point(0, -32768, 9));
		send_request(make_point(-1, 1, 10));
		send_request(make_point(-1000, 1, 11));
		// same direction three times: larger range keeps the old range, new intensity
		send_request(make_point(100, 100, 12));
		send_request(make_point(300, 300, 13));
		send_request(make_point(50, 50, 14));
		send_request(make_read(int'(bin_outcome_peek(50, 50))));
		send_request(make_read(0));
		send_request(make_read(627));
		send_request(make_read(628));
		drain();
	endtask

	// Mostly inserts of modest size with reads of bins within the beam count, some full-range noise
	task automatic test_random(input int count);
		ptab_pkg::req_t r;
		int roll, lim;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			lim = (cur_beams == 0) ? 1 : ((cur_beams > NBINS) ? NBINS : int'(cur_beams));
			if (roll < 30) begin
				r = make_read($urandom_range(lim - 1));
			end else if (roll < 35) begin
				r = make_read($urandom_range(1023));
			end else if (roll < 80) begin
				r = make_point($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
					$urandom);
			end else begin
				r = ptab_pkg::req_t'($bits(ptab_pkg::req_t)'({$urandom, $urandom}));
				r.func = ptab_pkg::FUNC_INSERT;
			end
			send_request(r);
		end
	endtask

	task automatic test_settings;
		// widest scan, finest step
		set_scan(-25736, 1, 1024);
		test_random(150);
		// one coarse bin at the top end
		set_scan(25736, 8192, 1);
		test_random(100);
		// zero step acts as one; oversized beam count
		set_scan(-25736, 0, 2047);
		test_random(150);
		// bin count too small for the angle span
		set_scan(0, 8192, 2);
		test_random(100);
		// unused register index changes nothing
		drain();
		write_reg(CFG_UNUSED, 16'hFFFF);
		write_reg(ptab_pkg::CFG_ANGLE_STEP, 16'h3FFF);
		test_random(100);
		for (int k = 0; k < 4; k++) begin
			set_scan($urandom_range(51472) - 25736, $urandom_range(8192, 1),
				$urandom_range(1024, 1));
			test_random(50);
		end
		set_scan(-25736, 82, 628);
	endtask

	task automatic test_idling;
		int pct [4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{35, 35}};
		for (int p = 0; p < 4; p++) begin
			idle_pct = pct[p][0];
			stall_pct = pct[p][1];
			test_random(100);
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		cur_start = -16'sd25736;
		cur_step = 14'd82;
		cur_beams = 11'd628;
		for (int i = 0; i < NBINS; i++) begin
			scan_range[i] = '0;
			scan_inten[i] = '0;
			scan_filled[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_idling();
		test_settings();
		idle_pct = 35;
		stall_pct = 35;
		test_random(100);
		drain();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
